/* rtl/hcrd_pkg.sv */
package hcrd_pkg;

  typedef enum logic [2:0] {
    PH_STATUS = 3'd0,
    PH_HEAD   = 3'd1,
    PH_SIZE   = 3'd2,
    PH_DATA   = 3'd3,
    PH_TAIL   = 3'd4,
    PH_DONE   = 3'd5,
    PH_STOP   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    SS_SPACE = 3'd0,
    SS_BLANK = 3'd1,
    SS_SIGN  = 3'd2,
    SS_DIGIT = 3'd3,
    SS_END   = 3'd4
  } status_scan_t;

  typedef enum logic [1:0] {
    ZS_BLANK = 2'd0,
    ZS_SIGN  = 2'd1,
    ZS_DIGIT = 2'd2,
    ZS_END   = 2'd3
  } size_scan_t;

  typedef enum logic [1:0] {
    VERDICT_PENDING = 2'd0,
    VERDICT_OK      = 2'd1,
    VERDICT_BUSY    = 2'd2,
    VERDICT_FAILED  = 2'd3
  } verdict_t;

  localparam logic       OP_FEED   = 1'b0;
  localparam logic       OP_CLEAR  = 1'b1;
  localparam logic [9:0] STATUS_OK   = 10'd200;
  localparam logic [9:0] STATUS_BUSY = 10'd503;
  localparam logic [9:0] STATUS_MAX  = 10'd1023;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      res = {1'b1, c[3:0]};
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      res = {1'b1, c[3:0] + 4'd9};
    end
    return res;
  endfunction

endpackage

/* rtl/http_chunked_reply_decoder_unit.sv */
// Chunked HTTP/1.1 reply decoder.
// The input channel (in_valid, in_stall, in_op, in_data_byte) takes one reply byte
// per beat; in_op set instead clears the decoder for a new reply. Every input beat
// gives exactly one result beat on the output channel (out_valid, out_stall and the
// out_ fields): a kept chunk payload byte with its end-of-chunk mark, plus the
// current status code, verdict and finished flag.
// The result of an accepted beat is registered and presented from the next cycle
// on. Throughput is one beat per cycle while out_stall is low; the whole state update
// is one pass of logic from the input ports into the state and result registers.
// The result register frees itself when its beat is taken, so a new input is
// accepted in the same cycle that the previous result leaves.
// When the receiver stalls, the result holds and in_stall rises, so no byte is
// taken until the held result is gone.
// Reset (rst_n low, synchronous) empties the result register and puts the
// decoder at the start of the status line, the same state a clear beat gives.
// Chunk payload beyond LINE_BYTES-1 bytes of a chunk is counted but not passed on.
module http_chunked_reply_decoder_unit #(
  parameter int LINE_BYTES = 128,
  parameter int SIZE_BITS  = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_data_valid,
  output logic [7:0] out_data_byte_out,
  output logic       out_piece_end,
  output logic [9:0] out_status_code,
  output logic [1:0] out_verdict,
  output logic       out_finished
);
  import hcrd_pkg::*;

  localparam int LC_W = (LINE_BYTES > 2) ? $clog2(LINE_BYTES) : 1;
  localparam logic [LC_W-1:0] LC_LAST = LC_W'(LINE_BYTES - 1);

  phase_t                 phase_r, phase_nxt;
  logic [LC_W-1:0]        line_count_r, line_count_nxt;
  logic [9:0]             status_value_r, status_value_nxt;
  status_scan_t           status_scan_r, status_scan_nxt;
  logic                   status_failed_r, status_failed_nxt;
  logic [SIZE_BITS-1:0]   size_accum_r, size_accum_nxt;
  size_scan_t             size_scan_r, size_scan_nxt;
  logic                   size_negative_r, size_negative_nxt;
  logic [SIZE_BITS-1:0]   bytes_left_r, bytes_left_nxt;

  logic                   out_valid_r;
  logic                   data_valid_r, data_valid_nxt;
  logic [7:0]             data_byte_r, data_byte_nxt;
  logic                   piece_end_r, piece_end_nxt;
  logic [9:0]             status_code_r, status_code_nxt;
  verdict_t               verdict_r, verdict_nxt;
  logic                   finished_r, finished_nxt;

  logic                   in_take;
  logic                   room;
  logic                   is_lf;
  logic                   is_cr;
  logic [13:0]            dec_sum;
  logic [4:0]             hex;
  logic                   size_ovf;
  logic [SIZE_BITS-1:0]   size_shift;
  logic [SIZE_BITS-1:0]   bytes_dec;

  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  assign room  = line_count_r < LC_LAST;
  assign is_lf = in_data_byte == CH_LF;
  assign is_cr = in_data_byte == CH_CR;

  assign dec_sum    = {1'b0, status_value_r, 3'b000} + {3'b000, status_value_r, 1'b0}
                    + {10'd0, in_data_byte[3:0]};
  assign hex        = hex_digit(in_data_byte);
  // Shifting in one more nibble overflows when the top nibble is already in use.
  assign size_ovf   = size_accum_r[SIZE_BITS-1 -: 4] != 4'd0;
  assign size_shift = {size_accum_r[SIZE_BITS-5:0], hex[3:0]};
  assign bytes_dec  = bytes_left_r - SIZE_BITS'(1);

  always_comb begin
    phase_nxt         = phase_r;
    line_count_nxt    = line_count_r;
    status_value_nxt  = status_value_r;
    status_scan_nxt   = status_scan_r;
    status_failed_nxt = status_failed_r;
    size_accum_nxt    = size_accum_r;
    size_scan_nxt     = size_scan_r;
    size_negative_nxt = size_negative_r;
    bytes_left_nxt    = bytes_left_r;
    data_valid_nxt    = 1'b0;
    data_byte_nxt     = 8'd0;
    piece_end_nxt     = 1'b0;

    if (in_op == OP_CLEAR) begin
      phase_nxt         = PH_STATUS;
      line_count_nxt    = '0;
      status_value_nxt  = '0;
      status_scan_nxt   = SS_SPACE;
      status_failed_nxt = 1'b0;
      size_accum_nxt    = '0;
      size_scan_nxt     = ZS_BLANK;
      size_negative_nxt = 1'b0;
      bytes_left_nxt    = '0;
    end else begin
      case (phase_r)
        PH_STATUS, PH_HEAD: begin
          if (room && !is_cr && !is_lf) begin
            line_count_nxt = line_count_r + LC_W'(1);
            if (phase_r == PH_STATUS) begin
              case (status_scan_r)
                SS_SPACE: begin
                  if (in_data_byte == CH_SPACE) status_scan_nxt = SS_BLANK;
                end
                SS_BLANK, SS_SIGN, SS_DIGIT: begin
                  if (status_scan_r == SS_BLANK && is_blank(in_data_byte)) begin
                    status_scan_nxt = SS_BLANK;
                  end else if (status_scan_r == SS_BLANK &&
                               (in_data_byte == CH_PLUS || in_data_byte == CH_MINUS)) begin
                    if (in_data_byte == CH_MINUS) status_failed_nxt = 1'b1;
                    status_scan_nxt = SS_SIGN;
                  end else if (is_dec(in_data_byte)) begin
                    status_value_nxt = (dec_sum > 14'(STATUS_MAX)) ? STATUS_MAX
                                                                   : dec_sum[9:0];
                    status_scan_nxt  = SS_DIGIT;
                  end else begin
                    status_scan_nxt = SS_END;
                  end
                end
                default: ;
              endcase
            end
          end
          if (is_lf) begin
            line_count_nxt = '0;
            if (phase_r == PH_STATUS) begin
              if (status_scan_r == SS_SPACE || status_failed_r) begin
                status_failed_nxt = 1'b1;
                status_value_nxt  = '0;
                phase_nxt         = PH_STOP;
              end else if (status_value_r == 10'd0) begin
                // No digits or a zero value: the next line is read as the status line again.
                status_scan_nxt = SS_SPACE;
              end else if (status_value_r == STATUS_OK) begin
                phase_nxt = PH_HEAD;
              end else begin
                phase_nxt = PH_STOP;
              end
            end else if (line_count_r == '0) begin
              phase_nxt         = PH_SIZE;
              size_accum_nxt    = '0;
              size_scan_nxt     = ZS_BLANK;
              size_negative_nxt = 1'b0;
            end
          end
        end
        PH_SIZE: begin
          if (is_lf) begin
            line_count_nxt = '0;
            if (size_negative_r || size_accum_r == '0) begin
              phase_nxt = PH_DONE;
            end else begin
              bytes_left_nxt = size_accum_r;
              phase_nxt      = PH_DATA;
            end
            size_accum_nxt    = '0;
            size_scan_nxt     = ZS_BLANK;
            size_negative_nxt = 1'b0;
          end else if (!is_cr && room) begin
            line_count_nxt = line_count_r + LC_W'(1);
            case (size_scan_r)
              ZS_BLANK, ZS_SIGN, ZS_DIGIT: begin
                if (size_scan_r == ZS_BLANK && is_blank(in_data_byte)) begin
                  size_scan_nxt = ZS_BLANK;
                end else if (size_scan_r == ZS_BLANK &&
                             (in_data_byte == CH_PLUS || in_data_byte == CH_MINUS)) begin
                  if (in_data_byte == CH_MINUS) size_negative_nxt = 1'b1;
                  size_scan_nxt = ZS_SIGN;
                end else if (hex[4]) begin
                  size_accum_nxt = size_ovf ? '1 : size_shift;
                  size_scan_nxt  = ZS_DIGIT;
                end else begin
                  size_scan_nxt = ZS_END;
                end
              end
              default: ;
            endcase
          end
        end
        PH_DATA: begin
          if (room) begin
            line_count_nxt = line_count_r + LC_W'(1);
            if (status_value_r == STATUS_OK) begin
              data_valid_nxt = 1'b1;
              data_byte_nxt  = in_data_byte;
            end
          end
          if (bytes_left_r != '0) bytes_left_nxt = bytes_dec;
          if (bytes_left_r <= SIZE_BITS'(1)) begin
            if (status_value_r == STATUS_OK) piece_end_nxt = 1'b1;
            line_count_nxt = '0;
            phase_nxt      = PH_TAIL;
          end
        end
        PH_TAIL: begin
          if (is_lf) phase_nxt = PH_SIZE;
        end
        default: ;
      endcase
    end

    if (phase_nxt == PH_DONE) begin
      verdict_nxt = VERDICT_OK;
    end else if (phase_nxt == PH_STOP) begin
      verdict_nxt = (!status_failed_nxt && status_value_nxt == STATUS_BUSY) ? VERDICT_BUSY
                                                                            : VERDICT_FAILED;
    end else begin
      verdict_nxt = VERDICT_PENDING;
    end
    status_code_nxt = (phase_nxt == PH_STATUS || status_failed_nxt) ? 10'd0 : status_value_nxt;
    finished_nxt    = phase_nxt == PH_DONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_STATUS;
      line_count_r    <= '0;
      status_value_r  <= '0;
      status_scan_r   <= SS_SPACE;
      status_failed_r <= 1'b0;
      size_accum_r    <= '0;
      size_scan_r     <= ZS_BLANK;
      size_negative_r <= 1'b0;
      bytes_left_r    <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_take) begin
        phase_r         <= phase_nxt;
        line_count_r    <= line_count_nxt;
        status_value_r  <= status_value_nxt;
        status_scan_r   <= status_scan_nxt;
        status_failed_r <= status_failed_nxt;
        size_accum_r    <= size_accum_nxt;
        size_scan_r     <= size_scan_nxt;
        size_negative_r <= size_negative_nxt;
        bytes_left_r    <= bytes_left_nxt;
        out_valid_r     <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      data_valid_r  <= data_valid_nxt;
      data_byte_r   <= data_byte_nxt;
      piece_end_r   <= piece_end_nxt;
      status_code_r <= status_code_nxt;
      verdict_r     <= verdict_nxt;
      finished_r    <= finished_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_valid    = data_valid_r;
  assign out_data_byte_out = data_byte_r;
  assign out_piece_end     = piece_end_r;
  assign out_status_code   = status_code_r;
  assign out_verdict       = verdict_r;
  assign out_finished      = finished_r;

  a_finished_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_verdict == VERDICT_OK)
    else $error("finished result without an ok verdict");

  a_payload_200: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> out_status_code == STATUS_OK && out_verdict == VERDICT_PENDING)
    else $error("payload byte passed on outside a pending 200 reply");

  a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_count_r <= LC_LAST)
    else $error("line count beyond the kept line length");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r)
    else $error("result present right after reset");

endmodule

/* tb/tb_http_chunked_reply_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_http_chunked_reply_decoder_unit;
  import hcrd_pkg::*;

  localparam int LINE_LIMIT    = 128;
  localparam int SIZE_WIDTH    = 32;
  localparam int ITEM_TARGET   = 1850;
  localparam int QUIET_TAIL    = 200;
  localparam int STALL_LIMIT   = 500;
  localparam logic [63:0] SIZE_TOP = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte_out;
    logic       piece_end;
    logic [9:0] status_code;
    logic [1:0] verdict;
    logic       finished;
  } reply_beat_t;

  class reply_scoreboard;
    reply_beat_t  expected_beats[$];
    int unsigned  mismatches;

    phase_t       phase;
    int unsigned  line_count;
    logic [9:0]   status_value;
    status_scan_t status_scan;
    bit           status_failed;
    logic [31:0]  size_accum;
    size_scan_t   size_scan;
    bit           size_negative;
    logic [31:0]  bytes_left;

    function new();
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase         = PH_STATUS;
      line_count    = 0;
      status_value  = '0;
      status_scan   = SS_SPACE;
      status_failed = 1'b0;
      size_accum    = '0;
      size_scan     = ZS_BLANK;
      size_negative = 1'b0;
      bytes_left    = '0;
    endfunction

    function bit blank_char(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
    endfunction

    function int hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      return -1;
    endfunction

    function void scan_status(logic [7:0] c);
      int unsigned v;
      case (status_scan)
        SS_SPACE: begin
          if (c == CH_SPACE) status_scan = SS_BLANK;
        end
        SS_BLANK, SS_SIGN, SS_DIGIT: begin
          if (status_scan == SS_BLANK && blank_char(c)) begin
          end else if (status_scan == SS_BLANK && (c == CH_PLUS || c == CH_MINUS)) begin
            if (c == CH_MINUS) status_failed = 1'b1;
            status_scan = SS_SIGN;
          end else if (c >= "0" && c <= "9") begin
            v = 32'(status_value) * 10 + 32'(c) - 48;
            status_value = (v > 1023) ? STATUS_MAX : v[9:0];
            status_scan = SS_DIGIT;
          end else begin
            status_scan = SS_END;
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void end_status_line();
      if (status_scan == SS_SPACE || status_failed) begin
        status_failed = 1'b1;
        status_value  = '0;
        phase         = PH_STOP;
      end else if (status_value == 0) begin
        // No digits or a zero value: the next line is tried as the status line.
        status_scan = SS_SPACE;
      end else if (status_value == STATUS_OK) begin
        phase = PH_HEAD;
      end else begin
        phase = PH_STOP;
      end
    endfunction

    function void scan_size(logic [7:0] c);
      int d;
      d = hex_nibble(c);
      case (size_scan)
        ZS_BLANK, ZS_SIGN, ZS_DIGIT: begin
          if (size_scan == ZS_BLANK && blank_char(c)) begin
          end else if (size_scan == ZS_BLANK && (c == CH_PLUS || c == CH_MINUS)) begin
            if (c == CH_MINUS) size_negative = 1'b1;
            size_scan = ZS_SIGN;
          end else if (d >= 0) begin
            if (64'(size_accum) > (SIZE_TOP - 64'(d)) / 16) size_accum = SIZE_TOP[31:0];
            else size_accum = size_accum * 16 + 32'(d);
            size_scan = ZS_DIGIT;
          end else begin
            size_scan = ZS_END;
          end
        end
        default: begin
        end
      endcase
    endfunction

    function reply_beat_t decode_byte(logic op, logic [7:0] c);
      reply_beat_t r;
      bit room;
      r = '0;
      room = (line_count + 1 < LINE_LIMIT);
      if (op == OP_CLEAR) begin
        clear_state();
      end else begin
        case (phase)
          PH_STATUS, PH_HEAD: begin
            if (room && c != CH_CR && c != CH_LF) begin
              line_count++;
              if (phase == PH_STATUS) scan_status(c);
            end
            if (c == CH_LF) begin
              if (phase == PH_STATUS) begin
                end_status_line();
              end else if (line_count == 0) begin
                phase         = PH_SIZE;
                size_accum    = '0;
                size_scan     = ZS_BLANK;
                size_negative = 1'b0;
              end
              line_count = 0;
            end
          end
          PH_SIZE: begin
            if (c == CH_LF) begin
              line_count = 0;
              if (size_negative || size_accum == 0) begin
                phase = PH_DONE;
              end else begin
                bytes_left = size_accum;
                phase      = PH_DATA;
              end
              size_accum    = '0;
              size_scan     = ZS_BLANK;
              size_negative = 1'b0;
            end else if (c != CH_CR && room) begin
              line_count++;
              scan_size(c);
            end
          end
          PH_DATA: begin
            if (room) begin
              line_count++;
              if (status_value == STATUS_OK) begin
                r.data_valid    = 1'b1;
                r.data_byte_out = c;
              end
            end
            if (bytes_left > 0) bytes_left--;
            if (bytes_left == 0) begin
              if (status_value == STATUS_OK) r.piece_end = 1'b1;
              line_count = 0;
              phase      = PH_TAIL;
            end
          end
          PH_TAIL: begin
            if (c == CH_LF) phase = PH_SIZE;
          end
          default: begin
          end
        endcase
      end

      if (phase == PH_DONE) r.verdict = VERDICT_OK;
      else if (phase == PH_STOP)
        r.verdict = (!status_failed && status_value == STATUS_BUSY) ? VERDICT_BUSY
                                                                    : VERDICT_FAILED;
      else r.verdict = VERDICT_PENDING;
      r.status_code = (phase == PH_STATUS || status_failed) ? 10'd0 : status_value;
      r.finished = (phase == PH_DONE);
      return r;
    endfunction

    function void note_input(logic op, logic [7:0] c);
      expected_beats.push_back(decode_byte(op, c));
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(reply_beat_t got);
      reply_beat_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected, got data_valid %0d byte %0d",
                 $time, got.data_valid, got.data_byte_out);
        mismatches++;
        return;
      end
      want = expected_beats.pop_front();
      compare_field("data_valid", want.data_valid, got.data_valid);
      compare_field("data_byte_out", want.data_byte_out, got.data_byte_out);
      compare_field("piece_end", want.piece_end, got.piece_end);
      compare_field("status_code", want.status_code, got.status_code);
      compare_field("verdict", want.verdict, got.verdict);
      compare_field("finished", want.finished, got.finished);
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_op = OP_FEED;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_data_valid;
  logic [7:0] out_data_byte_out;
  logic       out_piece_end;
  logic [9:0] out_status_code;
  logic [1:0] out_verdict;
  logic       out_finished;

  reply_scoreboard sb = new();
  logic [7:0]      reply_bytes[$];
  int unsigned     beats_sent = 0;
  bit              quiet = 1'b0;
  bit              sender_calm = 1'b0;

  http_chunked_reply_decoder_unit #(
    .LINE_BYTES(LINE_LIMIT),
    .SIZE_BITS (SIZE_WIDTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_valid   (out_data_valid),
    .out_data_byte_out(out_data_byte_out),
    .out_piece_end    (out_piece_end),
    .out_status_code  (out_status_code),
    .out_verdict      (out_verdict),
    .out_finished     (out_finished)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_beat(reply_beat_t'({out_data_valid, out_data_byte_out, out_piece_end,
                                   out_status_code, out_verdict, out_finished}));
  end

  // Receiver: random stall bursts between free-running stretches.
  initial begin
    int hold_cycles;
    hold_cycles = 0;
    forever begin
      @(posedge clk);
      if (quiet || !rst_n) begin
        out_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall   <= 1'b1;
        hold_cycles = $urandom_range(1, 8) - 1;
      end else begin
        out_stall   <= 1'b0;
        hold_cycles = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] b);
    int gap;
    if (!quiet && !sender_calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, b);
    beats_sent++;
    quiet = (beats_sent + QUIET_TAIL >= ITEM_TARGET);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_beats.size() != 0);
  endtask

  task automatic play_reply();
    foreach (reply_bytes[i]) send_beat(OP_FEED, reply_bytes[i]);
    reply_bytes.delete();
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) reply_bytes.push_back(s[i]);
  endfunction

  function automatic void add_eol();
    if ($urandom_range(0, 2) != 0) reply_bytes.push_back(CH_CR);
    reply_bytes.push_back(CH_LF);
  endfunction

  function automatic void add_blanks(int n);
    logic [7:0] blanks[4];
    blanks = '{8'h20, 8'h09, 8'h0B, 8'h0C};
    repeat (n) reply_bytes.push_back(blanks[$urandom_range(0, 3)]);
  endfunction

  function automatic void add_hex(logic [39:0] v, bit upper);
    logic [7:0] digits[$];
    logic [3:0] nib;
    do begin
      nib = v[3:0];
      if (nib < 10) digits.push_front(8'h30 + nib);
      else digits.push_front(8'((upper ? 8'h41 : 8'h61) + nib - 8'd10));
      v = v >> 4;
    end while (v != 0);
    foreach (digits[i]) reply_bytes.push_back(digits[i]);
  endfunction

  function automatic void add_status_line();
    case ($urandom_range(0, 15))
      0: add_text("HTTP/1.1");
      1: add_text($sformatf("HTTP/1.1 -%0d", $urandom_range(0, 600)));
      2: begin
        add_text("HTTP/1.1 OK");
        add_eol();
        add_text("HTTP/1.1 200");
      end
      3: add_text("HTTP/1.1 503 Service Unavailable");
      4: add_text($sformatf("HTTP/1.1 %0d", $urandom_range(0, 1) ? $urandom_range(0, 1100)
                                                                   : $urandom_range(0, 999999)));
      5: begin
        // The space falls beyond the kept part of the line.
        repeat (130) reply_bytes.push_back("a");
        add_text(" 200");
      end
      6: begin
        add_text("HTTP/1.1 ");
        add_blanks($urandom_range(0, 3));
        add_text("+0200");
      end
      default: add_text("HTTP/1.1 200 OK");
    endcase
    add_eol();
  endfunction

  function automatic void add_header_line();
    int len;
    logic [7:0] c;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(120, 180) : $urandom_range(1, 24);
    repeat (len) begin
      if ($urandom_range(0, 15) == 0) c = 8'($urandom);
      else c = 8'($urandom_range(8'h21, 8'h7E));
      if (c == CH_LF) c = 8'h0B;
      reply_bytes.push_back(c);
    end
    add_eol();
  endfunction

  // Returns 1 when the chunk can never end, so the reply is left open.
  function automatic bit add_chunk();
    int pick;
    logic [39:0] sz;
    pick = $urandom_range(0, 29);
    if (pick == 0) sz = {8'($urandom), 32'($urandom)} | 40'h01_0000_0000;
    else if (pick < 5) sz = 40'($urandom_range(100, 140));
    else sz = 40'($urandom_range(1, 6));
    if ($urandom_range(0, 2) == 0) add_blanks($urandom_range(1, 2));
    if ($urandom_range(0, 5) == 0) reply_bytes.push_back(CH_PLUS);
    repeat ($urandom_range(0, 2)) reply_bytes.push_back("0");
    add_hex(sz, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 5) == 0) add_text(";name=val");
    add_eol();
    if (pick == 0) begin
      repeat ($urandom_range(1, 10)) reply_bytes.push_back(8'($urandom));
      return 1'b1;
    end
    repeat (int'(sz)) reply_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 7) == 0) add_text("zz");
    add_eol();
    return 1'b0;
  endfunction

  function automatic void add_last_chunk();
    case ($urandom_range(0, 7))
      0: add_text("0x1F");
      1: add_text("-4");
      2: add_text("000;last");
      3: begin
        // The digit lies past the kept part, so the size reads as zero.
        repeat (130) reply_bytes.push_back(CH_SPACE);
        add_text("7");
      end
      4: begin
      end
      default: add_text("0");
    endcase
    add_eol();
    if ($urandom_range(0, 1)) add_eol();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 5)) reply_bytes.push_back(8'($urandom));
  endfunction

  function automatic void build_reply();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(3, 40)) reply_bytes.push_back(8'($urandom));
      return;
    end
    add_status_line();
    repeat ($urandom_range(0, 3)) add_header_line();
    add_eol();
    repeat ($urandom_range(1, 4)) if (add_chunk()) return;
    add_last_chunk();
  endfunction

  initial begin
    int unsigned reply_count;
    int cut;
    reply_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(OP_CLEAR, 8'hFF);
    add_text("x\n");
    reply_bytes.push_back("A");
    play_reply();
    send_beat(OP_CLEAR, 8'h00);
    add_text(" -1\n");
    play_reply();
    send_beat(OP_CLEAR, 8'h5A);
    add_text(" \n 503\n");
    play_reply();
    send_beat(OP_CLEAR, 8'hA5);
    add_text(" 200\n\n1\n");
    reply_bytes.push_back(8'hFF);
    add_text("\n2\n");
    reply_bytes.push_back(8'h00);
    reply_bytes.push_back(8'h80);
    add_text("\n0\n");
    reply_bytes.push_back(8'h00);
    play_reply();
    drain_results();

    while (beats_sent < ITEM_TARGET) begin
      reply_count++;
      sender_calm = ($urandom_range(0, 3) == 0);
      build_reply();
      // Now and then the reply is cut short by a clear.
      if ($urandom_range(0, 9) == 0 && reply_bytes.size() > 1) begin
        cut = $urandom_range(1, reply_bytes.size() - 1);
        while (reply_bytes.size() > cut) void'(reply_bytes.pop_back());
      end
      play_reply();
      send_beat(OP_CLEAR, 8'($urandom));
      if (reply_count % 8 == 0) drain_results();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_beats.size() != 0);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
